[rtl/ecac_pkg.sv]
// Shared constants, types and codes for the circular autocorrelation core.
package ecac_pkg;

    localparam int MAX_BLOCK   = 1024;
    localparam int MAX_LAGS    = 64;
    localparam int SAMPLE_BITS = 16;

    localparam int ABITS     = $clog2(MAX_BLOCK);
    localparam int LBITS     = $clog2(MAX_LAGS);
    localparam int BS_W      = 11;
    localparam int LC_W      = 7;
    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam int CNT_W     = 16;
    localparam int ACC_W     = 64;
    localparam int TOT_W     = 48;
    localparam int NB_W      = BS_W + CNT_W;
    localparam int PROD_W    = 2 * SAMPLE_BITS;

    // wide multiplier: A by B, B taken one digit at a time
    localparam int WA_W   = 64;
    localparam int WB_W   = 48;
    localparam int DIG_W  = 16;
    localparam int NDIG   = WB_W / DIG_W;
    localparam int DK_W   = $clog2(NDIG);
    localparam int WP_W   = WA_W + WB_W;

    // signed width of numerator and denominator
    localparam int NW     = 98;
    localparam int Q_W    = 16;
    localparam int QK_W   = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = '1;

    localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LAG_COUNT  = 2'd1;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOBLK = 2'd1;
    localparam logic [1:0] ST_ZVAR  = 2'd2;
    localparam logic [1:0] ST_SAT   = 2'd3;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;

    typedef struct packed {
        logic             start;
        logic             lag0;
        logic [ABITS-1:0] sh;
    } mac_ctl_t;

endpackage

[rtl/ecac_mac.sv]
// Sample store and pipelined lag multiply-accumulate for one lag of a block.
module ecac_mac (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [ecac_pkg::ABITS-1:0]        wr_addr,
    input  ecac_pkg::sample_t                 wr_data,
    input  ecac_pkg::mac_ctl_t                ctl,
    input  logic [ecac_pkg::BS_W-1:0]         n,
    output logic                              done,
    output logic signed [ecac_pkg::ACC_W-1:0] acc,
    output logic signed [ecac_pkg::TOT_W-1:0] sum
);
    import ecac_pkg::*;

    sample_t mem [MAX_BLOCK];

    logic             iss_reg, iss_next;
    logic [ABITS-1:0] i_reg, i_next;
    logic [ABITS-1:0] j_reg, j_next;
    logic             lag0_reg;
    logic             v1_reg, l1_reg, v2_reg, l2_reg, done_reg;
    sample_t          a1_reg, b1_reg, a2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [TOT_W-1:0]  sum_reg;
    logic             last_i;
    logic [BS_W-1:0]  j_inc;

    assign last_i = ({1'b0, i_reg} == n - 1'b1);
    assign j_inc  = {1'b0, j_reg} + 1'b1;

    always_comb
    begin
        iss_next = iss_reg;
        i_next   = i_reg;
        j_next   = j_reg;
        if (ctl.start)
        begin
            iss_next = 1'b1;
            i_next   = '0;
            j_next   = ctl.sh;
        end
        else if (iss_reg)
        begin
            i_next = i_reg + 1'b1;
            j_next = (j_inc == n) ? '0 : j_inc[ABITS-1:0];
            if (last_i)
                iss_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        a1_reg <= mem[i_reg];
        b1_reg <= mem[j_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iss_reg  <= 1'b0;
            i_reg    <= '0;
            j_reg    <= '0;
            lag0_reg <= 1'b0;
            v1_reg   <= 1'b0;
            l1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            l2_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            iss_reg  <= iss_next;
            i_reg    <= i_next;
            j_reg    <= j_next;
            if (ctl.start)
                lag0_reg <= ctl.lag0;
            v1_reg   <= iss_reg;
            l1_reg   <= iss_reg && last_i;
            v2_reg   <= v1_reg;
            l2_reg   <= l1_reg;
            done_reg <= v2_reg && l2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= a1_reg * b1_reg;
        a2_reg   <= a1_reg;
        if (ctl.start)
        begin
            acc_reg <= '0;
            sum_reg <= '0;
        end
        else if (v2_reg)
        begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
            if (lag0_reg)
                sum_reg <= sum_reg + TOT_W'(a2_reg);
        end
    end

    assign done = done_reg;
    assign acc  = acc_reg;
    assign sum  = sum_reg;

endmodule

[rtl/ecac_wmul.sv]
// Wide unsigned multiplier, one 16-bit digit of B per step.
module ecac_wmul (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [ecac_pkg::WA_W-1:0]   a,
    input  logic [ecac_pkg::WB_W-1:0]   b,
    output logic                        done,
    output logic [ecac_pkg::WP_W-1:0]   p
);
    import ecac_pkg::*;

    logic                    busy_reg, ppv_reg, done_reg;
    logic [DK_W-1:0]         k_reg, ppk_reg;
    logic [WA_W-1:0]         a_reg;
    logic [WB_W-1:0]         b_reg;
    logic [WA_W+DIG_W-1:0]   pp_reg;
    logic [WP_W-1:0]         acc_reg;
    logic                    last_k;

    assign last_k = (k_reg == DK_W'(NDIG - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            ppv_reg  <= busy_reg;
            done_reg <= ppv_reg && (ppk_reg == DK_W'(NDIG - 1));
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (last_k)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            a_reg   <= a;
            b_reg   <= b;
            acc_reg <= '0;
        end
        else if (ppv_reg)
            acc_reg <= acc_reg + (WP_W'(pp_reg) << (ppk_reg * DIG_W));
        pp_reg  <= a_reg * b_reg[k_reg*DIG_W +: DIG_W];
        ppk_reg <= k_reg;
    end

    assign done = done_reg;
    assign p    = acc_reg;

endmodule

[rtl/ecac_div.sv]
// Restoring divider giving a saturated Q1.15 ratio, one quotient bit per cycle.
module ecac_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [ecac_pkg::NW-1:0]  num,
    input  logic signed [ecac_pkg::NW-1:0]  den,
    output logic                            done,
    output logic signed [ecac_pkg::Q_W-1:0] q
);
    import ecac_pkg::*;

    logic              busy_reg, done_reg;
    logic [QK_W-1:0]   k_reg;
    logic [NW:0]       r_reg;
    logic [NW-1:0]     ad_reg;
    logic [Q_W-1:0]    q_reg;
    logic              neg_reg, sat_reg;
    logic [NW-1:0]     an, ad;
    logic [NW:0]       cand;
    logic              ge;
    logic [Q_W:0]      qv;

    assign an   = num[NW-1] ? -num : num;
    assign ad   = den[NW-1] ? -den : den;
    assign cand = (k_reg == '0) ? r_reg : {r_reg[NW-1:0], 1'b0};
    assign ge   = cand >= {1'b0, ad_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            k_reg    <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (k_reg == '1);
            if (start)
            begin
                busy_reg <= 1'b1;
                k_reg    <= '0;
            end
            else if (busy_reg)
            begin
                k_reg <= k_reg + 1'b1;
                if (k_reg == '1)
                    busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg   <= {1'b0, an};
            ad_reg  <= ad;
            q_reg   <= '0;
            neg_reg <= num[NW-1] ^ den[NW-1];
            // ratio of two or more saturates either way
            sat_reg <= {1'b0, an} >= {ad, 1'b0};
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? cand - {1'b0, ad_reg} : cand;
            q_reg <= {q_reg[Q_W-2:0], ge};
        end
    end

    always_comb
    begin
        qv = sat_reg ? {1'b1, {Q_W{1'b0}}} : {1'b0, q_reg};
        if (neg_reg)
            q = (qv > (Q_W+1)'(32768)) ? Q_W'(-32768) : Q_W'(-qv);
        else
            q = (qv > (Q_W+1)'(32767)) ? Q_W'(32767) : Q_W'(qv);
    end

    assign done = done_reg;

endmodule

[rtl/ensemble_circular_autocorrelation_core.sv]
// Block-averaged circular autocorrelation core: sequencer, lag totals, output register.
//
// Input channel (in_valid/in_ready, cmd, sample): cmd 0 requests a sample,
// cmd 1 requests a finish. The sample that completes a block starts the
// lag pass unless the block count is at its maximum; the pass runs the
// single multiply-accumulate pipe over every lag, with one sample-memory
// read pair and one multiplier per product.
// in_ready is low during that pass.
// A finish runs, for each lag, the wide digit multiplier and then 16 divider
// steps, and emits lag_count results, lag 0 first, last on the final one;
// an empty run or a zero denominator gives a single error result.
// The run state is then cleared.
// Output channel (out_valid/out_ready): one result register; a stalled
// receiver holds the sequencer before the next result is loaded.
// Configuration (cfg_we, cfg_index, cfg_data) writes block_size (0) or
// lag_count (1) and clears the run; write only while idle.
// Reset: registers to 64 / 32, run state empty, ready at once.
module ensemble_circular_autocorrelation_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [ecac_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [ecac_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              cmd,
    input  logic signed [ecac_pkg::SAMPLE_BITS-1:0] sample,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ecac_pkg::LBITS-1:0]        lag_index,
    output logic signed [15:0]                corr_value,
    output logic [1:0]                        status,
    output logic                              last
);
    import ecac_pkg::*;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_CORR  = 4'd1;
    localparam logic [3:0] S_LWR   = 4'd2;
    localparam logic [3:0] S_FSET  = 4'd3;
    localparam logic [3:0] S_FT2   = 4'd4;
    localparam logic [3:0] S_FRD   = 4'd5;
    localparam logic [3:0] S_FNUM  = 4'd6;
    localparam logic [3:0] S_FMW   = 4'd7;
    localparam logic [3:0] S_FDIV  = 4'd8;
    localparam logic [3:0] S_FEMIT = 4'd9;
    localparam logic [3:0] S_FERR  = 4'd10;

    logic [3:0]          state_reg, state_next;
    logic [BS_W-1:0]     bs_reg, bs_next;
    logic [LC_W-1:0]     lc_reg, lc_next;
    logic [BS_W-1:0]     fill_reg, fill_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                ovf_reg, ovf_next;
    logic [TOT_W-1:0]    total_reg, total_next;
    logic [MAX_LAGS-1:0] lvalid_reg, lvalid_next;
    logic [LBITS-1:0]    l_reg, l_next;
    logic [ABITS-1:0]    sh_reg, sh_next;
    logic [1:0]          err_reg, err_next;
    logic                out_valid_reg, out_valid_next;

    logic [NB_W-1:0]     nb_reg;
    logic [NW-1:0]       t2_reg;
    logic signed [NW-1:0] den_reg;
    logic                sneg_reg;
    logic [LBITS-1:0]    lag_index_reg;
    logic signed [15:0]  corr_value_reg;
    logic [1:0]          status_reg;
    logic                last_reg;

    logic                load_out;
    logic [LBITS-1:0]    out_lag;
    logic signed [15:0]  out_corr;
    logic [1:0]          out_status;
    logic                out_last;

    logic [BS_W-1:0]     n_eff;
    logic [LC_W-1:0]     lags_eff;
    logic [ACC_W-1:0]    lmem [MAX_LAGS];
    logic [ACC_W-1:0]    tot_q;
    logic                lv_q;
    logic [ACC_W-1:0]    tot;
    logic                lmem_we;
    logic [ACC_W-1:0]    lmem_wdata;

    logic                samp_we;
    mac_ctl_t            mac_ctl;
    logic                mac_done;
    logic signed [ACC_W-1:0] mac_acc;
    logic signed [TOT_W-1:0] mac_sum;

    logic                wmul_start, wmul_done;
    logic [WA_W-1:0]     wmul_a;
    logic [WB_W-1:0]     wmul_b;
    logic [WP_W-1:0]     wmul_p;
    logic [TOT_W-1:0]    tmag;
    logic [ACC_W-1:0]    smag;
    logic signed [NW-1:0] pv, num;
    logic                div_start, div_done;
    logic signed [NW-1:0] div_den;
    logic signed [15:0]  div_q;
    logic                lag_last;
    logic [BS_W-1:0]     fill_inc, sh_inc;
    logic                slot_free;

    assign n_eff = (bs_reg == '0) ? BS_W'(1) :
                   (bs_reg > BS_W'(MAX_BLOCK)) ? BS_W'(MAX_BLOCK) : bs_reg;
    assign lags_eff = (lc_reg == '0) ? LC_W'(1) :
                      (lc_reg > LC_W'(MAX_LAGS)) ? LC_W'(MAX_LAGS) : lc_reg;

    assign in_ready  = (state_reg == S_IDLE);
    assign slot_free = !out_valid_reg || out_ready;
    assign lag_last  = ({1'b0, l_reg} + 1'b1 == lags_eff);
    assign fill_inc  = fill_reg + 1'b1;
    assign sh_inc    = {1'b0, sh_reg} + 1'b1;
    assign tot       = lv_q ? tot_q : '0;
    assign tmag      = total_reg[TOT_W-1] ? -total_reg : total_reg;
    assign smag      = tot[ACC_W-1] ? -tot : tot;
    assign wmul_a    = (state_reg == S_FSET) ? WA_W'(tmag) : smag;
    assign wmul_b    = (state_reg == S_FSET) ? tmag : WB_W'(nb_reg);
    assign pv        = sneg_reg ? -wmul_p[NW-1:0] : wmul_p[NW-1:0];
    assign num       = pv - t2_reg;
    assign div_den   = (l_reg == '0) ? num : den_reg;

    always_comb
    begin
        state_next     = state_reg;
        bs_next        = bs_reg;
        lc_next        = lc_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        ovf_next       = ovf_reg;
        total_next     = total_reg;
        lvalid_next    = lvalid_reg;
        l_next         = l_reg;
        sh_next        = sh_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        samp_we        = 1'b0;
        mac_ctl        = '0;
        lmem_we        = 1'b0;
        lmem_wdata     = tot + mac_acc;
        wmul_start     = 1'b0;
        div_start      = 1'b0;
        load_out       = 1'b0;
        out_lag        = '0;
        out_corr       = '0;
        out_status     = err_reg;
        out_last       = 1'b1;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (cmd == CMD_FINISH)
                        state_next = S_FSET;
                    else
                    begin
                        samp_we = 1'b1;
                        if (fill_inc >= n_eff)
                        begin
                            fill_next = '0;
                            if (count_reg == COUNT_MAX)
                                ovf_next = 1'b1;
                            else
                            begin
                                state_next    = S_CORR;
                                l_next        = '0;
                                sh_next       = '0;
                                mac_ctl.start = 1'b1;
                                mac_ctl.lag0  = 1'b1;
                            end
                        end
                        else
                            fill_next = fill_inc;
                    end
                end
            end
            S_CORR:
            begin
                if (mac_done)
                    state_next = S_LWR;
            end
            S_LWR:
            begin
                lmem_we            = 1'b1;
                lvalid_next[l_reg] = 1'b1;
                if (l_reg == '0)
                    total_next = total_reg + mac_sum;
                if (lag_last)
                begin
                    count_next = count_reg + 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    l_next        = l_reg + 1'b1;
                    sh_next       = (sh_inc == n_eff) ? '0 : sh_inc[ABITS-1:0];
                    mac_ctl.start = 1'b1;
                    mac_ctl.sh    = sh_next;
                    state_next    = S_CORR;
                end
            end
            S_FSET:
            begin
                l_next = '0;
                if (count_reg == '0)
                begin
                    err_next   = ST_NOBLK;
                    state_next = S_FERR;
                end
                else
                begin
                    wmul_start = 1'b1;
                    state_next = S_FT2;
                end
            end
            S_FT2:
            begin
                if (wmul_done)
                    state_next = S_FRD;
            end
            S_FRD:
                state_next = S_FNUM;
            S_FNUM:
            begin
                wmul_start = 1'b1;
                state_next = S_FMW;
            end
            S_FMW:
            begin
                if (wmul_done)
                begin
                    if (l_reg == '0 && num == '0)
                    begin
                        err_next   = ST_ZVAR;
                        state_next = S_FERR;
                    end
                    else
                    begin
                        div_start  = 1'b1;
                        state_next = S_FDIV;
                    end
                end
            end
            S_FDIV:
            begin
                if (div_done)
                    state_next = S_FEMIT;
            end
            S_FEMIT:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    out_lag        = l_reg;
                    out_corr       = div_q;
                    out_status     = ovf_reg ? ST_SAT : ST_OK;
                    out_last       = lag_last;
                    if (lag_last)
                    begin
                        state_next  = S_IDLE;
                        fill_next   = '0;
                        count_next  = '0;
                        ovf_next    = 1'b0;
                        total_next  = '0;
                        lvalid_next = '0;
                    end
                    else
                    begin
                        l_next     = l_reg + 1'b1;
                        state_next = S_FRD;
                    end
                end
            end
            S_FERR:
            begin
                if (slot_free)
                begin
                    load_out       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                    fill_next      = '0;
                    count_next     = '0;
                    ovf_next       = 1'b0;
                    total_next     = '0;
                    lvalid_next    = '0;
                end
            end
            default:
                state_next = S_IDLE;
        endcase

        // register write restarts the run
        if (cfg_we && (cfg_index == REG_BLOCK_SIZE || cfg_index == REG_LAG_COUNT))
        begin
            if (cfg_index == REG_BLOCK_SIZE)
                bs_next = cfg_data[BS_W-1:0];
            else
                lc_next = cfg_data[LC_W-1:0];
            fill_next   = '0;
            count_next  = '0;
            ovf_next    = 1'b0;
            total_next  = '0;
            lvalid_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            bs_reg        <= BS_W'(64);
            lc_reg        <= LC_W'(32);
            fill_reg      <= '0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            total_reg     <= '0;
            lvalid_reg    <= '0;
            l_reg         <= '0;
            sh_reg        <= '0;
            err_reg       <= ST_OK;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bs_reg        <= bs_next;
            lc_reg        <= lc_next;
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            ovf_reg       <= ovf_next;
            total_reg     <= total_next;
            lvalid_reg    <= lvalid_next;
            l_reg         <= l_next;
            sh_reg        <= sh_next;
            err_reg       <= err_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (lmem_we)
            lmem[l_reg] <= lmem_wdata;
        tot_q <= lmem[l_reg];
        lv_q  <= lvalid_reg[l_reg];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_FSET)
            nb_reg <= NB_W'(n_eff) * NB_W'(count_reg);
        if (state_reg == S_FT2 && wmul_done)
            t2_reg <= wmul_p[NW-1:0];
        if (state_reg == S_FNUM)
            sneg_reg <= tot[ACC_W-1];
        if (state_reg == S_FMW && wmul_done && l_reg == '0)
            den_reg <= num;
        if (load_out)
        begin
            lag_index_reg  <= out_lag;
            corr_value_reg <= out_corr;
            status_reg     <= out_status;
            last_reg       <= out_last;
        end
    end

    ecac_mac u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (samp_we),
        .wr_addr (fill_reg[ABITS-1:0]),
        .wr_data (sample),
        .ctl     (mac_ctl),
        .n       (n_eff),
        .done    (mac_done),
        .acc     (mac_acc),
        .sum     (mac_sum)
    );

    ecac_wmul u_wmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (wmul_start),
        .a     (wmul_a),
        .b     (wmul_b),
        .done  (wmul_done),
        .p     (wmul_p)
    );

    ecac_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (div_den),
        .done  (div_done),
        .q     (div_q)
    );

    assign out_valid  = out_valid_reg;
    assign lag_index  = lag_index_reg;
    assign corr_value = corr_value_reg;
    assign status     = status_reg;
    assign last       = last_reg;

    a_fill_below_block: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> (fill_reg < n_eff))
        else $error("block fill reached block size while idle");

    a_mac_done_in_corr: assert property (@(posedge clk) disable iff (!rst_n)
        mac_done |-> (state_reg == S_CORR))
        else $error("lag pass finished outside correlation state");

    a_wmul_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        wmul_done |-> (state_reg == S_FT2 || state_reg == S_FMW))
        else $error("wide product finished in unexpected state");

    a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == S_FDIV))
        else $error("divider finished outside divide state");

endmodule
